// ----- hdl/tccw_pkg.sv -----
// package for the text console cell writer: operation codes, register indexes,
// character constants and the sequencer's control store
// no dependencies
package tccw_pkg;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int RIDX_W  = 11;
    localparam int CELL_W  = 16;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;
    localparam int COLOR_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'h0a;
    localparam logic [CHAR_W-1:0] SPACE_CODE    = 8'h20;
    localparam logic [7:0]        DEFAULT_COLOR = 8'h07;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_PUT,
        STEP_DONE,
        STEP_MOVE_PRIME,
        STEP_MOVE,
        STEP_BLANK_ROW,
        STEP_CLEAR,
        STEP_RD_ISSUE,
        STEP_RD_DATA
    } t_step;

    typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} t_cnt_op;
    typedef enum logic [1:0] {WR_NONE, WR_CHAR, WR_BLANK, WR_MOVE} t_wr_src;
    typedef enum logic [1:0] {RD_NONE, RD_HOST, RD_MOVE_FIRST, RD_MOVE_NEXT} t_rd_src;
    typedef enum logic [1:0] {CUR_HOLD, CUR_PUT, CUR_HOME} t_cur_op;
    typedef enum logic [2:0] {
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_SCROLL,
        JMP_LOOP,
        JMP_WAIT_OUT
    } t_jump;
    typedef enum logic {LIM_MOVE, LIM_ALL} t_limit;

    typedef struct packed {
        logic    in_ready;
        t_cnt_op cnt_op;
        t_wr_src wr_src;
        t_rd_src rd_src;
        t_cur_op cur_op;
        logic    cell_load;
        logic    out_load;
        t_jump   jump;
        t_limit  limit;
        t_step   target;
    } t_ctrl;

    // one control word per step
    function automatic t_ctrl ctrl_rom(t_step s);
        t_ctrl w;
        w = '{in_ready: 1'b0, cnt_op: CNT_HOLD, wr_src: WR_NONE, rd_src: RD_NONE,
              cur_op: CUR_HOLD, cell_load: 1'b0, out_load: 1'b0, jump: JMP_GOTO,
              limit: LIM_ALL, target: STEP_IDLE};
        unique case (s)
            STEP_IDLE: begin
                w.in_ready = 1'b1;
                w.cnt_op   = CNT_CLR;
                w.jump     = JMP_DISPATCH;
            end
            STEP_PUT: begin
                w.wr_src = WR_CHAR;
                w.cur_op = CUR_PUT;
                w.jump   = JMP_SCROLL;
                w.target = STEP_MOVE_PRIME;
            end
            STEP_DONE: begin
                w.out_load = 1'b1;
                w.jump     = JMP_WAIT_OUT;
                w.target   = STEP_IDLE;
            end
            STEP_MOVE_PRIME: begin
                w.rd_src = RD_MOVE_FIRST;
                w.target = STEP_MOVE;
            end
            STEP_MOVE: begin
                w.wr_src = WR_MOVE;
                w.rd_src = RD_MOVE_NEXT;
                w.cnt_op = CNT_INC;
                w.jump   = JMP_LOOP;
                w.limit  = LIM_MOVE;
                w.target = STEP_BLANK_ROW;
            end
            STEP_BLANK_ROW: begin
                w.wr_src = WR_BLANK;
                w.cnt_op = CNT_INC;
                w.jump   = JMP_LOOP;
                w.target = STEP_DONE;
            end
            STEP_CLEAR: begin
                w.wr_src = WR_BLANK;
                w.cnt_op = CNT_INC;
                w.cur_op = CUR_HOME;
                w.jump   = JMP_LOOP;
                w.target = STEP_DONE;
            end
            STEP_RD_ISSUE: begin
                w.rd_src = RD_HOST;
                w.target = STEP_RD_DATA;
            end
            STEP_RD_DATA: begin
                w.cell_load = 1'b1;
                w.target    = STEP_DONE;
            end
            default: begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // entry step for each operation
    function automatic t_step dispatch(logic [OP_W-1:0] op);
        t_step s;
        unique case (op)
            OP_PUT:   s = STEP_PUT;
            OP_CLEAR: s = STEP_CLEAR;
            OP_READ:  s = STEP_RD_ISSUE;
            default:  s = STEP_DONE;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/tccw_if.sv -----
// valid/ready channel interfaces for the console command and result beats
// depends on tccw_pkg for field widths
interface tccw_in_if;
    logic                            valid;
    logic                            ready;
    logic [tccw_pkg::OP_W-1:0]       op;
    logic [tccw_pkg::CHAR_W-1:0]     char_code;
    logic [tccw_pkg::RIDX_W-1:0]     read_index;

    modport source (output valid, output op, output char_code, output read_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input read_index,
                    output ready);
endinterface

interface tccw_out_if;
    logic                            valid;
    logic                            ready;
    logic [tccw_pkg::CELL_W-1:0]     cell_entry;
    logic [tccw_pkg::CROW_W-1:0]     cursor_line;
    logic [tccw_pkg::CCOL_W-1:0]     cursor_col;

    modport source (output valid, output cell_entry, output cursor_line,
                    output cursor_col, input ready);
    modport sink   (input valid, input cell_entry, input cursor_line,
                    input cursor_col, output ready);
endinterface

// ----- hdl/text_console_cell_writer.sv -----
// text console cell writer: puts, reads, clears and puts that scroll are handled one item at a time
// by a sequencer that drives the single write port of the screen memory, which the scroll and
// clear sweeps walk a cell a cycle
// a finished result waits in the output register while the next beat is taken
// synchronous active-low reset clears cursor, sequencer and output valid and sets the colors to fg 7, bg 0;
// screen memory is not cleared and holds garbage until the first clear
module text_console_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tccw_in_if.sink                             i_in,
    tccw_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]        i_cfg_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int SW = AW + 2;

    localparam logic [AW:0]   LIMIT_MOVE = (AW+1)'(CELL_COUNT - COLUMNS - 1);
    localparam logic [AW:0]   LIMIT_ALL  = (AW+1)'(CELL_COUNT - 1);
    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_ROW_A = AW'((ROWS - 1) * COLUMNS);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

    logic [tccw_pkg::CELL_W-1:0] mem [CELL_COUNT];

    tccw_pkg::t_step r_step, n_step;
    tccw_pkg::t_ctrl ctrl;

    logic [AW:0]   r_cnt, n_cnt;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_lin, n_lin;
    logic [tccw_pkg::COLOR_W-1:0] r_fg, r_bg;

    logic [tccw_pkg::OP_W-1:0]   r_op;
    logic [tccw_pkg::CHAR_W-1:0] r_char;
    logic [tccw_pkg::RIDX_W-1:0] r_ridx;
    logic [tccw_pkg::CELL_W-1:0] r_rdata;
    logic [tccw_pkg::CELL_W-1:0] r_cell;

    logic                        r_out_valid;
    logic [tccw_pkg::CELL_W-1:0] r_out_cell;
    logic [tccw_pkg::CROW_W-1:0] r_out_row;
    logic [tccw_pkg::CCOL_W-1:0] r_out_col;

    logic        in_beat, out_beat, can_load, is_newline, need_scroll, host_ok;
    logic [7:0]  color;
    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [tccw_pkg::CELL_W-1:0] wr_data;
    logic [SW-1:0] move_addr;

    assign ctrl     = tccw_pkg::ctrl_rom(r_step);
    assign in_beat  = i_in.valid && ctrl.in_ready;
    assign out_beat = r_out_valid && o_out.ready;
    assign can_load = !r_out_valid || o_out.ready;

    assign i_in.ready        = ctrl.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.cell_entry  = r_out_cell;
    assign o_out.cursor_line = r_out_row;
    assign o_out.cursor_col  = r_out_col;

    assign color       = ({r_bg, r_fg} == 8'h00) ? tccw_pkg::DEFAULT_COLOR : {r_bg, r_fg};
    assign is_newline  = (r_char == tccw_pkg::NEWLINE_CODE);
    assign need_scroll = (r_row == LAST_ROW) && (is_newline || r_col == LAST_COL);
    assign host_ok     = (32'(r_ridx) < 32'(CELL_COUNT));

    // next step
    always_comb begin
        n_step = r_step;
        unique case (ctrl.jump)
            tccw_pkg::JMP_GOTO:     n_step = ctrl.target;
            tccw_pkg::JMP_DISPATCH: if (in_beat) n_step = tccw_pkg::dispatch(i_in.op);
            tccw_pkg::JMP_SCROLL:   n_step = need_scroll ? ctrl.target : tccw_pkg::STEP_DONE;
            tccw_pkg::JMP_LOOP: begin
                if (r_cnt == ((ctrl.limit == tccw_pkg::LIM_MOVE) ? LIMIT_MOVE : LIMIT_ALL))
                    n_step = ctrl.target;
            end
            tccw_pkg::JMP_WAIT_OUT: if (can_load) n_step = ctrl.target;
            default:                n_step = tccw_pkg::STEP_IDLE;
        endcase
    end

    // datapath controls from the control word
    always_comb begin
        n_cnt = r_cnt;
        unique case (ctrl.cnt_op)
            tccw_pkg::CNT_CLR: n_cnt = '0;
            tccw_pkg::CNT_INC: n_cnt = r_cnt + 1'b1;
            default:           n_cnt = r_cnt;
        endcase

        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = {color, tccw_pkg::SPACE_CODE};
        unique case (ctrl.wr_src)
            tccw_pkg::WR_CHAR: begin
                wr_en   = !is_newline;
                wr_addr = r_lin;
                wr_data = {color, r_char};
            end
            tccw_pkg::WR_BLANK: wr_en = 1'b1;
            tccw_pkg::WR_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
            end
            default: wr_en = 1'b0;
        endcase

        move_addr = SW'(r_cnt) + SW'(COLUMNS) + SW'(1);
        rd_en   = 1'b0;
        rd_addr = COLS_A;
        unique case (ctrl.rd_src)
            tccw_pkg::RD_HOST: begin
                rd_en   = host_ok;
                rd_addr = AW'(r_ridx);
            end
            tccw_pkg::RD_MOVE_FIRST: rd_en = 1'b1;
            tccw_pkg::RD_MOVE_NEXT: begin
                // the last move needs no further source cell
                rd_en   = (move_addr < SW'(CELL_COUNT));
                rd_addr = move_addr[AW-1:0];
            end
            default: rd_en = 1'b0;
        endcase

        n_row = r_row;
        n_col = r_col;
        n_lin = r_lin;
        unique case (ctrl.cur_op)
            tccw_pkg::CUR_PUT: begin
                if (need_scroll) begin
                    n_row = LAST_ROW;
                    n_col = '0;
                    n_lin = LAST_ROW_A;
                end else if (is_newline) begin
                    n_row = r_row + 1'b1;
                    n_col = '0;
                    n_lin = r_lin - AW'(r_col) + COLS_A;
                end else if (r_col == LAST_COL) begin
                    n_row = r_row + 1'b1;
                    n_col = '0;
                    n_lin = r_lin + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                    n_lin = r_lin + 1'b1;
                end
            end
            tccw_pkg::CUR_HOME: begin
                n_row = '0;
                n_col = '0;
                n_lin = '0;
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    // screen memory
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= tccw_pkg::STEP_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_lin       <= '0;
            r_fg        <= 4'd7;
            r_bg        <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_row  <= n_row;
            r_col  <= n_col;
            r_lin  <= n_lin;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tccw_pkg::REG_FG_COLOR: r_fg <= i_cfg_data;
                    tccw_pkg::REG_BG_COLOR: r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.out_load && can_load) r_out_valid <= 1'b1;
            else if (out_beat)             r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (in_beat) begin
            r_op   <= i_in.op;
            r_char <= i_in.char_code;
            r_ridx <= i_in.read_index;
            r_cell <= '0;
        end else if (ctrl.cell_load) begin
            r_cell <= (r_op == tccw_pkg::OP_READ && host_ok) ? r_rdata : '0;
        end
        if (ctrl.out_load && can_load) begin
            r_out_cell <= r_cell;
            r_out_row  <= tccw_pkg::CROW_W'(r_row);
            r_out_col  <= tccw_pkg::CCOL_W'(r_col);
        end
    end

    // a clear beat starts the clearing sweep
    a_clear_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_in.op == tccw_pkg::OP_CLEAR) |=> (r_step == tccw_pkg::STEP_CLEAR))
        else $error("clear beat did not start the sweep");

    // linear cursor address tracks row and column
    a_lin_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lin == AW'(int'(r_row) * COLUMNS + int'(r_col))) && (int'(r_row) < ROWS))
        else $error("cursor address out of step with row and column");

    // writes stay inside the screen
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) < 32'(CELL_COUNT)))
        else $error("screen write outside the cell range");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_cell)))
        else $error("pending result was overwritten");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for text_console_cell_writer: directed and random command traffic on the valid/ready
// channels, checked beat by beat against an in-bench model of the 80x25 screen
// depends on tccw_pkg, tccw_if and the console writer rtl
module tb_top;

    localparam int COLS  = 80;
    localparam int LINES = 25;
    localparam int CELLS = COLS * LINES;
    localparam int IDX_W = $clog2(CELLS);
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned PHASE_ITEMS = 290;

    // register slots the block has to ignore
    localparam logic [tccw_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [tccw_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [tccw_pkg::CELL_W-1:0] entry;
        logic [tccw_pkg::CROW_W-1:0] row;
        logic [tccw_pkg::CCOL_W-1:0] col;
    } t_report;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tccw_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tccw_pkg::COLOR_W-1:0]   i_cfg_data;

    tccw_in_if  in_ch ();
    tccw_out_if out_ch ();

    text_console_cell_writer #(
        .COLUMNS(COLS),
        .ROWS   (LINES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the screen, cursor and colors
    logic [tccw_pkg::CELL_W-1:0]  screen_shadow [CELLS];
    logic [tccw_pkg::CROW_W-1:0]  shadow_row = '0;
    logic [tccw_pkg::CCOL_W-1:0]  shadow_col = '0;
    logic [tccw_pkg::COLOR_W-1:0] shadow_fg  = 4'd7;
    logic [tccw_pkg::COLOR_W-1:0] shadow_bg  = 4'd0;

    t_report      pending_reports [$];
    int unsigned  fault_count  = 0;
    int unsigned  items_sent   = 0;
    int unsigned  cycle_count  = 0;
    bit           no_idle      = 1'b0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [tccw_pkg::CHAR_W-1:0] rand_char();
        return tccw_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [tccw_pkg::RIDX_W-1:0] rand_idx();
        return tccw_pkg::RIDX_W'($urandom_range(0, 2047));
    endfunction

    function automatic logic [7:0] color_byte();
        logic [7:0] c;
        c = {shadow_bg, shadow_fg};
        return (c == 8'h00) ? tccw_pkg::DEFAULT_COLOR : c;
    endfunction

    function automatic void blank_cells(int first, int last);
        for (int i = first; i < last; i++)
            screen_shadow[IDX_W'(i)] = {color_byte(), tccw_pkg::SPACE_CODE};
    endfunction

    function automatic t_report console_apply(logic [tccw_pkg::OP_W-1:0] op,
                                              logic [tccw_pkg::CHAR_W-1:0] ch,
                                              logic [tccw_pkg::RIDX_W-1:0] idx);
        t_report r;
        int pos;
        r.entry = '0;
        case (op)
            tccw_pkg::OP_PUT: begin
                if (ch == tccw_pkg::NEWLINE_CODE) begin
                    shadow_col = '0;
                    shadow_row = shadow_row + 1'b1;
                end else begin
                    pos = shadow_row * COLS + shadow_col;
                    if (pos < CELLS)
                        screen_shadow[IDX_W'(pos)] = {color_byte(), ch};
                    shadow_col = shadow_col + 1'b1;
                    if (shadow_col >= COLS) begin
                        shadow_col = '0;
                        shadow_row = shadow_row + 1'b1;
                    end
                end
                // ran off the bottom: scroll up one line
                if (shadow_row >= LINES) begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        screen_shadow[IDX_W'(i)] = screen_shadow[IDX_W'(i + COLS)];
                    blank_cells(CELLS - COLS, CELLS);
                    shadow_col = '0;
                    shadow_row = tccw_pkg::CROW_W'(LINES - 1);
                end
            end
            tccw_pkg::OP_CLEAR: begin
                blank_cells(0, CELLS);
                shadow_row = '0;
                shadow_col = '0;
            end
            tccw_pkg::OP_READ: begin
                if (idx < CELLS)
                    r.entry = screen_shadow[idx];
            end
            default: begin
            end
        endcase
        r.row = shadow_row;
        r.col = shadow_col;
        return r;
    endfunction

    // one command beat; valid stays up when the next beat follows with no gap
    task automatic issue_command(input logic [tccw_pkg::OP_W-1:0] op,
                                 input logic [tccw_pkg::CHAR_W-1:0] ch,
                                 input logic [tccw_pkg::RIDX_W-1:0] idx);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.char_code  <= ch;
        in_ch.read_index <= idx;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_reports.push_back(console_apply(op, ch, idx));
        if (op != tccw_pkg::OP_NOP)
            items_sent++;
    endtask

    task automatic finish_phase();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_colors(input logic [tccw_pkg::COLOR_W-1:0] fg,
                              input logic [tccw_pkg::COLOR_W-1:0] bg);
        finish_phase();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tccw_pkg::REG_FG_COLOR;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        i_cfg_index <= tccw_pkg::REG_BG_COLOR;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE_A;
        i_cfg_data  <= tccw_pkg::COLOR_W'($urandom_range(0, 15));
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE_B;
        i_cfg_data  <= tccw_pkg::COLOR_W'($urandom_range(0, 15));
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        shadow_fg = fg;
        shadow_bg = bg;
    endtask

    function automatic logic [tccw_pkg::CHAR_W-1:0] random_glyph();
        logic [tccw_pkg::CHAR_W-1:0] g;
        g = rand_char();
        return (g == tccw_pkg::NEWLINE_CODE) ? tccw_pkg::SPACE_CODE : g;
    endfunction

    function automatic logic [tccw_pkg::RIDX_W-1:0] read_target();
        case ($urandom_range(0, 9)) inside
            0:       return tccw_pkg::RIDX_W'($urandom_range(CELLS, 2047));
            [1:3]:   return tccw_pkg::RIDX_W'(shadow_row * COLS
                                              + $urandom_range(0, COLS - 1));
            4:       return tccw_pkg::RIDX_W'((LINES - 1) * COLS
                                              + $urandom_range(0, COLS - 1));
            default: return tccw_pkg::RIDX_W'($urandom_range(0, CELLS - 1));
        endcase
    endfunction

    task automatic test_reset_state();
        issue_command(tccw_pkg::OP_NOP, 8'hff, 11'h7ff);
        issue_command(tccw_pkg::OP_PUT, 8'h41, 11'h000);
    endtask

    task automatic test_clear_and_range();
        issue_command(tccw_pkg::OP_CLEAR, 8'h00, 11'h000);
        issue_command(tccw_pkg::OP_READ, 8'h00, 11'd0);
        issue_command(tccw_pkg::OP_READ, 8'hff, tccw_pkg::RIDX_W'(CELLS - 1));
        issue_command(tccw_pkg::OP_READ, 8'h00, tccw_pkg::RIDX_W'(CELLS));
        issue_command(tccw_pkg::OP_READ, 8'hff, 11'h7ff);
    endtask

    task automatic test_put_extremes();
        issue_command(tccw_pkg::OP_PUT, 8'h00, 11'h7ff);
        issue_command(tccw_pkg::OP_PUT, 8'hff, 11'h000);
        issue_command(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE, 11'h000);
        issue_command(tccw_pkg::OP_PUT, 8'h7e, 11'h000);
        issue_command(tccw_pkg::OP_READ, 8'h00, 11'd0);
        issue_command(tccw_pkg::OP_READ, 8'h00, 11'd1);
        issue_command(tccw_pkg::OP_READ, 8'h00, tccw_pkg::RIDX_W'(COLS));
        issue_command(tccw_pkg::OP_READ, 8'h00, 11'd2);
        issue_command(tccw_pkg::OP_NOP, 8'h00, 11'h000);
    endtask

    // both color registers zero falls back to light grey on black
    task automatic test_zero_color();
        set_colors(4'd0, 4'd0);
        issue_command(tccw_pkg::OP_PUT, 8'h5a, 11'h000);
        issue_command(tccw_pkg::OP_READ, 8'h00, tccw_pkg::RIDX_W'(COLS + 1));
        issue_command(tccw_pkg::OP_CLEAR, 8'h00, 11'h000);
        issue_command(tccw_pkg::OP_READ, 8'h00, 11'd0);
        set_colors(4'd15, 4'd15);
        issue_command(tccw_pkg::OP_PUT, 8'h41, 11'h000);
        issue_command(tccw_pkg::OP_READ, 8'h00, 11'd0);
    endtask

    // walk the cursor to the bottom, then wrap and scroll with random text
    task automatic test_wrap_scroll();
        set_colors(4'd7, 4'd0);
        for (int k = 0; k < LINES - 1; k++)
            issue_command(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE, rand_idx());
        for (int k = 0; k < COLS + 3; k++)
            issue_command(tccw_pkg::OP_PUT, random_glyph(), rand_idx());
        for (int k = 0; k < 6; k++)
            issue_command(tccw_pkg::OP_READ, rand_char(),
                          tccw_pkg::RIDX_W'((LINES - 2 + k % 2) * COLS + k));
        issue_command(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE, 11'h000);
        issue_command(tccw_pkg::OP_READ, 8'h00, tccw_pkg::RIDX_W'((LINES - 2) * COLS));
    endtask

    task automatic run_episode();
        int unsigned kind;
        int unsigned n;
        kind    = $urandom_range(0, 99);
        no_idle = ($urandom_range(0, 3) == 0);
        if (kind < 45) begin
            n = $urandom_range(1, 90);
            for (int k = 0; k < n; k++) begin
                issue_command(tccw_pkg::OP_PUT, random_glyph(), rand_idx());
                if ($urandom_range(0, 9) == 0)
                    issue_command(tccw_pkg::OP_READ, rand_char(), read_target());
            end
            if ($urandom_range(0, 9) < 7)
                issue_command(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE, rand_idx());
        end else if (kind < 65) begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                issue_command(tccw_pkg::OP_READ, rand_char(), read_target());
        end else if (kind < 73) begin
            n = $urandom_range(1, LINES);
            for (int k = 0; k < n; k++)
                issue_command(tccw_pkg::OP_PUT, tccw_pkg::NEWLINE_CODE, rand_idx());
        end else if (kind < 76) begin
            issue_command(tccw_pkg::OP_CLEAR, rand_char(), rand_idx());
        end else if (kind < 88) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                issue_command(tccw_pkg::OP_W'($urandom_range(0, 3)), rand_char(),
                              rand_idx());
        end else begin
            // run just past the end of the current line
            n = COLS - shadow_col + $urandom_range(0, 3);
            for (int k = 0; k < n; k++)
                issue_command(tccw_pkg::OP_PUT, random_glyph(), rand_idx());
            issue_command(tccw_pkg::OP_READ, 8'h00, read_target());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic(input logic [tccw_pkg::COLOR_W-1:0] fg,
                                       input logic [tccw_pkg::COLOR_W-1:0] bg);
        int unsigned target;
        set_colors(fg, bg);
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            run_episode();
    endtask

    // result sink with random back-pressure
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = idle_cycles();
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no command pending");
                fault_count++;
            end else begin
                want = pending_reports.pop_front();
                if (out_ch.cell_entry !== want.entry) begin
                    $error("cell_entry: expected %h, got %h", want.entry, out_ch.cell_entry);
                    fault_count++;
                end
                if (out_ch.cursor_line !== want.row) begin
                    $error("cursor_line: expected %0d, got %0d", want.row,
                           out_ch.cursor_line);
                    fault_count++;
                end
                if (out_ch.cursor_col !== want.col) begin
                    $error("cursor_col: expected %0d, got %0d", want.col, out_ch.cursor_col);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = tccw_pkg::OP_NOP;
        in_ch.char_code  = '0;
        in_ch.read_index = '0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = tccw_pkg::REG_FG_COLOR;
        i_cfg_data       = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_clear_and_range();
        test_put_extremes();
        test_zero_color();
        test_wrap_scroll();
        test_random_traffic(4'd15, 4'd15);
        test_random_traffic(4'd0, 4'd0);
        test_random_traffic(4'd0, 4'd15);
        test_random_traffic(4'd15, 4'd0);
        test_random_traffic(tccw_pkg::COLOR_W'($urandom_range(0, 15)),
                            tccw_pkg::COLOR_W'($urandom_range(0, 15)));
        test_random_traffic(tccw_pkg::COLOR_W'($urandom_range(0, 15)),
                            tccw_pkg::COLOR_W'($urandom_range(0, 15)));

        finish_phase();
        // a stray beat would show up within one full sweep
        repeat (CELLS + 100) @(posedge i_clk);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
